[hw/rtl/pplp_pkg.sv]
// Package for the pure pursuit lookahead point block: widths, pipeline stage map,
// saturation limits and the payload structs that travel down the pipeline.
// No dependencies; used by pure_pursuit_lookahead_point and pplp_checker.
package pplp_pkg;

    // Coordinate width. Coordinates are Q16.16, but the math is scale free, so the
    // number of fraction bits never enters the logic.
    localparam int CW     = 32;
    localparam int N      = CW + 1;          // width of a coordinate difference
    localparam int H      = CW + 1;          // half width used to split wide operands
    localparam int LAW    = CW - 1;          // lookahead radius width
    localparam int DRW    = 2 * H;           // squared segment length
    localparam int DMW    = 2 * H;           // magnitude of the cross product
    localparam int RW     = 2 * H;           // square root width
    localparam int RMW    = RW + 3;          // square root trial width
    localparam int PPW    = H + CW;          // partial product of the numerator terms
    localparam int MW     = 3 * CW + 2;      // magnitude of one numerator term
    localparam int NW     = 3 * CW + 3;      // signed numerator
    localparam int NUMW   = 3 * CW + 4;      // rounded dividend
    localparam int QW     = CW + 1;          // quotient bits below the limit
    localparam int VW     = CW + 2;          // limited quotient magnitude
    localparam int SW     = CW + 4;          // sum before saturation

    // Stream widths.
    localparam int IN_FW  = 6 * CW + LAW;
    localparam int IN_W   = ((IN_FW + 7) / 8) * 8;
    localparam int OUT_W  = 2 * CW;
    localparam int USER_W = 2;
    localparam int U_DEGEN = 0;
    localparam int U_CLIP  = 1;

    // Pipeline stage map.
    localparam int ST_SQ  = 8;               // square root seed stage
    localparam int TP     = ST_SQ + RW + 1;  // numerator partial products
    localparam int ST_DV  = TP + 5;          // divider seed stage
    localparam int PL     = ST_DV + QW + 1;  // translate back
    localparam int OUTS   = PL + 1;          // output register
    localparam int DEPTH  = OUTS + 1;

    // Saturation limits of a coordinate.
    localparam logic signed [SW-1:0] LIM_HI = SW'({1'b0, {(CW-1){1'b1}}});
    localparam logic signed [SW-1:0] LIM_LO = -LIM_HI - SW'(1);

    // Per item values carried along from the setup stages to the end.
    typedef struct packed {
        logic signed [CW-1:0] rx;
        logic signed [CW-1:0] ry;
        logic signed [CW-1:0] ex;
        logic signed [CW-1:0] ey;
        logic                 degen;
        logic [CW-1:0]        dxmag;
        logic                 dxneg;
        logic [CW-1:0]        dymag;
        logic                 dyneg;
        logic [DMW-1:0]       dmag;
        logic                 dneg;
        logic [DRW-1:0]       dr;
        logic                 wneg;
        logic                 wzero;
    } t_car;

    // One axis of the restoring divider.
    typedef struct packed {
        logic [NUMW-1:0] rem;
        logic [QW-1:0]   q;
        logic            sat;
        logic            neg;
    } t_div;

endpackage

[hw/rtl/pure_pursuit_lookahead_point.sv]
// Top level of the pure pursuit lookahead point block: a fully pipelined line and
// circle intersection with a bit per stage square root and divider.
// Depends on pplp_pkg.
//
// Channel   Direction  Transfer carries
// s_axis    in         robot, segment start, segment end, lookahead radius
// m_axis    out        chosen point; tuser holds the degenerate and clipped flags
//
// One item enters per cycle while the output is not stalled; the pipeline has one
// stage per root bit and one stage per quotient bit.
// Reset is synchronous and active low and clears only the valid bits.
// When a result waits at the output and is not taken, the whole pipeline holds;
// the input is ready again in the cycle the output transfer completes.
module pure_pursuit_lookahead_point (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // robot_x, robot_y, start_x, start_y, end_x, end_y, lookahead, zero fill
    input  logic [pplp_pkg::IN_W-1:0]      i_s_axis_tdata,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // aim_x, aim_y
    output logic [pplp_pkg::OUT_W-1:0]     o_m_axis_tdata,
    // degenerate, clipped
    output logic [pplp_pkg::USER_W-1:0]    o_m_axis_tuser
);

    localparam int CW   = pplp_pkg::CW;
    localparam int N    = pplp_pkg::N;
    localparam int H    = pplp_pkg::H;
    localparam int LAW  = pplp_pkg::LAW;
    localparam int DRW  = pplp_pkg::DRW;
    localparam int DMW  = pplp_pkg::DMW;
    localparam int RW   = pplp_pkg::RW;
    localparam int RMW  = pplp_pkg::RMW;
    localparam int PPW  = pplp_pkg::PPW;
    localparam int MW   = pplp_pkg::MW;
    localparam int NW   = pplp_pkg::NW;
    localparam int NUMW = pplp_pkg::NUMW;
    localparam int QW   = pplp_pkg::QW;
    localparam int VW   = pplp_pkg::VW;
    localparam int SW   = pplp_pkg::SW;
    localparam int PL   = pplp_pkg::PL;
    localparam int OUTS = pplp_pkg::OUTS;
    localparam int DEPTH = pplp_pkg::DEPTH;

    logic en;
    logic [DEPTH-1:0] r_vld;

    // Pipeline advance: hold everything while the output register is stalled.
    assign en              = !r_vld[OUTS] || i_m_axis_tready;
    assign o_s_axis_tready = en;
    assign o_m_axis_tvalid = r_vld[OUTS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[DEPTH-2:0], i_s_axis_tvalid};
        end
    end

    // Input fields.
    logic signed [CW-1:0] w_rx, w_ry, w_sx, w_sy, w_ex, w_ey;
    logic [LAW-1:0]       w_la;
    assign w_rx = i_s_axis_tdata[0*CW +: CW];
    assign w_ry = i_s_axis_tdata[1*CW +: CW];
    assign w_sx = i_s_axis_tdata[2*CW +: CW];
    assign w_sy = i_s_axis_tdata[3*CW +: CW];
    assign w_ex = i_s_axis_tdata[4*CW +: CW];
    assign w_ey = i_s_axis_tdata[5*CW +: CW];
    assign w_la = i_s_axis_tdata[6*CW +: LAW];

    // Stage 0: move the segment so the robot sits at the origin.
    logic signed [N-1:0]  r0_x1, r0_y1, r0_x2, r0_y2, r0_dx, r0_dy;
    logic signed [CW-1:0] r0_rx, r0_ry, r0_ex, r0_ey;
    logic [LAW-1:0]       r0_la;
    logic                 r0_degen;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_x1    <= N'(w_sx) - N'(w_rx);
            r0_y1    <= N'(w_sy) - N'(w_ry);
            r0_x2    <= N'(w_ex) - N'(w_rx);
            r0_y2    <= N'(w_ey) - N'(w_ry);
            r0_dx    <= N'(w_ex) - N'(w_sx);
            r0_dy    <= N'(w_ey) - N'(w_sy);
            r0_rx    <= w_rx;
            r0_ry    <= w_ry;
            r0_ex    <= w_ex;
            r0_ey    <= w_ey;
            r0_la    <= w_la;
            r0_degen <= (w_ex == w_sx) && (w_ey == w_sy);
        end
    end

    // Stage 1: the first products.
    logic signed [2*N-1:0] r1_dxdx, r1_dydy, r1_x1y2, r1_x2y1, r1_dxx2, r1_dyy2;
    logic [2*LAW-1:0]      r1_la2;
    logic signed [N-1:0]   r1_dx, r1_dy;
    logic signed [CW-1:0]  r1_rx, r1_ry, r1_ex, r1_ey;
    logic                  r1_degen;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_dxdx  <= r0_dx * r0_dx;
            r1_dydy  <= r0_dy * r0_dy;
            r1_x1y2  <= r0_x1 * r0_y2;
            r1_x2y1  <= r0_x2 * r0_y1;
            r1_dxx2  <= r0_dx * r0_x2;
            r1_dyy2  <= r0_dy * r0_y2;
            r1_la2   <= r0_la * r0_la;
            r1_dx    <= r0_dx;
            r1_dy    <= r0_dy;
            r1_rx    <= r0_rx;
            r1_ry    <= r0_ry;
            r1_ex    <= r0_ex;
            r1_ey    <= r0_ey;
            r1_degen <= r0_degen;
        end
    end

    // Stage 2: squared length, cross product and the dot product with the endpoint.
    logic [DRW-1:0]       r2_dr;
    logic signed [2*N:0]  r2_d, r2_w;
    logic [2*LAW-1:0]     r2_la2;
    logic signed [N-1:0]  r2_dx, r2_dy;
    logic signed [CW-1:0] r2_rx, r2_ry, r2_ex, r2_ey;
    logic                 r2_degen;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_dr    <= $unsigned(r1_dxdx) + $unsigned(r1_dydy);
            r2_d     <= (2*N+1)'(r1_x1y2) - (2*N+1)'(r1_x2y1);
            r2_w     <= (2*N+1)'(r1_dxx2) + (2*N+1)'(r1_dyy2);
            r2_la2   <= r1_la2;
            r2_dx    <= r1_dx;
            r2_dy    <= r1_dy;
            r2_rx    <= r1_rx;
            r2_ry    <= r1_ry;
            r2_ex    <= r1_ex;
            r2_ey    <= r1_ey;
            r2_degen <= r1_degen;
        end
    end

    // Stage 3: sign and magnitude form of everything carried to the end.
    pplp_pkg::t_car r_car [3:PL];
    logic [2*LAW-1:0] r3_la2;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_car[3].rx    <= r2_rx;
            r_car[3].ry    <= r2_ry;
            r_car[3].ex    <= r2_ex;
            r_car[3].ey    <= r2_ey;
            r_car[3].degen <= r2_degen;
            r_car[3].dxmag <= r2_dx[N-1] ? CW'(-r2_dx) : CW'(r2_dx);
            r_car[3].dxneg <= r2_dx[N-1];
            r_car[3].dymag <= r2_dy[N-1] ? CW'(-r2_dy) : CW'(r2_dy);
            r_car[3].dyneg <= r2_dy[N-1];
            r_car[3].dmag  <= r2_d[2*N] ? DMW'(-r2_d) : DMW'(r2_d);
            r_car[3].dneg  <= r2_d[2*N];
            r_car[3].dr    <= r2_dr;
            r_car[3].wneg  <= r2_w[2*N];
            r_car[3].wzero <= (r2_w == '0);
            r3_la2         <= r2_la2;
        end
    end

    for (genvar g = 4; g <= PL; g++) begin : g_car
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_car[g] <= r_car[g-1];
            end
        end
    end

    // Stage 4: partial products of lookahead^2 * dr and |d|^2.
    logic [2*H-1:0] w4_a, w4_b, w4_c;
    logic [2*H-1:0] r4_a_ll, r4_a_lh, r4_a_hl, r4_a_hh;
    logic [2*H-1:0] r4_b_ll, r4_b_lh, r4_b_hl, r4_b_hh;
    assign w4_a = (2*H)'(r3_la2);
    assign w4_b = r_car[3].dr;
    assign w4_c = r_car[3].dmag;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_a_ll <= w4_a[H-1:0]   * w4_b[H-1:0];
            r4_a_lh <= w4_a[H-1:0]   * w4_b[2*H-1:H];
            r4_a_hl <= w4_a[2*H-1:H] * w4_b[H-1:0];
            r4_a_hh <= w4_a[2*H-1:H] * w4_b[2*H-1:H];
            r4_b_ll <= w4_c[H-1:0]   * w4_c[H-1:0];
            r4_b_lh <= w4_c[H-1:0]   * w4_c[2*H-1:H];
            r4_b_hl <= w4_c[2*H-1:H] * w4_c[H-1:0];
            r4_b_hh <= w4_c[2*H-1:H] * w4_c[2*H-1:H];
        end
    end

    // Stage 5: place the outer partials and add the cross partials.
    logic [4*H-1:0] r5_a_t1, r5_b_t1;
    logic [2*H:0]   r5_a_t2, r5_b_t2;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_a_t1 <= {r4_a_hh, r4_a_ll};
            r5_b_t1 <= {r4_b_hh, r4_b_ll};
            r5_a_t2 <= (2*H+1)'(r4_a_lh) + (2*H+1)'(r4_a_hl);
            r5_b_t2 <= (2*H+1)'(r4_b_lh) + (2*H+1)'(r4_b_hl);
        end
    end

    // Stage 6: full products.
    logic [4*H-1:0] r6_pa, r6_pb;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_pa <= r5_a_t1 + ((4*H)'(r5_a_t2) << H);
            r6_pb <= r5_b_t1 + ((4*H)'(r5_b_t2) << H);
        end
    end

    // Stage 7: discriminant.
    logic signed [4*H:0] r7_sd;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_sd <= $signed({1'b0, r6_pa}) - $signed({1'b0, r6_pb});
        end
    end

    // Stage 8 seeds the square root with the magnitude of the discriminant.
    logic [RMW-3:0]  r_sq_rem  [0:RW];
    logic [RW-1:0]   r_sq_root [0:RW];
    logic [2*RW-1:0] r_sq_rad  [0:RW-1];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq_rem[0]  <= '0;
            r_sq_root[0] <= '0;
            r_sq_rad[0]  <= r7_sd[4*H] ? (2*RW)'(-r7_sd) : r7_sd[4*H-1:0];
        end
    end

    // Square root, one root bit per stage.
    for (genvar k = 1; k <= RW; k++) begin : g_sqrt
        logic [RMW-1:0] n_cur, n_trial;
        logic           n_take;
        assign n_cur   = {r_sq_rem[k-1], r_sq_rad[k-1][2*RW-1 -: 2]};
        assign n_trial = RMW'({r_sq_root[k-1], 2'b01});
        assign n_take  = (n_cur >= n_trial);
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sq_rem[k]  <= n_take ? (RMW-2)'(n_cur - n_trial) : (RMW-2)'(n_cur);
                r_sq_root[k] <= {r_sq_root[k-1][RW-2:0], n_take};
            end
        end
        if (k < RW) begin : g_rad
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_sq_rad[k] <= r_sq_rad[k-1] << 2;
                end
            end
        end
    end

    // First numerator stage: pick the candidate and form the partial products.
    // Terms: 0 = d*dy, 1 = ux*root, 2 = -d*dx, 3 = |dy|*root.
    pplp_pkg::t_car w_ct;
    logic [RW-1:0]  w_root;
    logic           w_first, w_rneg;
    logic [PPW-1:0] r_t1_lo [0:3];
    logic [PPW-1:0] r_t1_hi [0:3];
    logic [3:0]     r_t1_sg;
    assign w_ct    = r_car[pplp_pkg::TP-1];
    assign w_root  = r_sq_root[RW];
    assign w_first = (w_root == '0) || w_ct.wzero || (w_ct.wneg == w_ct.dyneg);
    assign w_rneg  = !w_first;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t1_lo[0] <= w_ct.dmag[H-1:0]   * w_ct.dymag;
            r_t1_hi[0] <= w_ct.dmag[2*H-1:H] * w_ct.dymag;
            r_t1_lo[1] <= w_root[H-1:0]      * w_ct.dxmag;
            r_t1_hi[1] <= w_root[2*H-1:H]    * w_ct.dxmag;
            r_t1_lo[2] <= w_ct.dmag[H-1:0]   * w_ct.dxmag;
            r_t1_hi[2] <= w_ct.dmag[2*H-1:H] * w_ct.dxmag;
            r_t1_lo[3] <= w_root[H-1:0]      * w_ct.dymag;
            r_t1_hi[3] <= w_root[2*H-1:H]    * w_ct.dymag;
            r_t1_sg[0] <= w_ct.dneg ^ w_ct.dyneg;
            r_t1_sg[1] <= w_ct.dxneg ^ w_ct.dyneg ^ w_rneg;
            r_t1_sg[2] <= !(w_ct.dneg ^ w_ct.dxneg);
            r_t1_sg[3] <= w_rneg;
        end
    end

    // Term magnitudes, then signed terms, then the two numerators.
    logic [MW-1:0]        r_t2_mag [0:3];
    logic [3:0]           r_t2_sg;
    logic signed [NW-1:0] r_t3_sv  [0:3];
    logic signed [NW-1:0] r_t4_nx, r_t4_ny;
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                r_t2_mag[i] <= (MW'(r_t1_hi[i]) << H) + MW'(r_t1_lo[i]);
                r_t3_sv[i]  <= r_t2_sg[i] ? -$signed({1'b0, r_t2_mag[i]})
                                          :  $signed({1'b0, r_t2_mag[i]});
            end
            r_t2_sg <= r_t1_sg;
            r_t4_nx <= r_t3_sv[0] + r_t3_sv[1];
            r_t4_ny <= r_t3_sv[2] + r_t3_sv[3];
        end
    end

    // Rounding dividend 2|n| + dr and divisor 2 dr.
    logic signed [NUMW:0] n_num_x, n_num_y;
    logic [NUMW-1:0]      r_t5_num_x, r_t5_num_y;
    logic                 r_t5_neg_x, r_t5_neg_y;
    logic [DRW:0]         r_t5_den;
    logic [DRW-1:0]       w_dr5;
    assign w_dr5 = r_car[pplp_pkg::TP+3].dr;
    always_comb begin
        logic signed [NW:0] n2x, n2y;
        n2x = {r_t4_nx, 1'b0};
        n2y = {r_t4_ny, 1'b0};
        n_num_x = $signed({1'b0, NUMW'(w_dr5)})
                + (r_t4_nx[NW-1] ? -(NUMW+1)'(n2x) : (NUMW+1)'(n2x));
        n_num_y = $signed({1'b0, NUMW'(w_dr5)})
                + (r_t4_ny[NW-1] ? -(NUMW+1)'(n2y) : (NUMW+1)'(n2y));
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t5_num_x <= n_num_x[NUMW-1:0];
            r_t5_num_y <= n_num_y[NUMW-1:0];
            r_t5_neg_x <= r_t4_nx[NW-1];
            r_t5_neg_y <= r_t4_ny[NW-1];
            r_t5_den   <= {w_dr5, 1'b0};
        end
    end

    // Divider seed: a quotient at or above the limit saturates.
    pplp_pkg::t_div r_dvx [0:QW];
    pplp_pkg::t_div r_dvy [0:QW];
    logic [DRW:0]   r_den [0:QW-1];
    logic [NUMW-1:0] w_dlim;
    assign w_dlim = NUMW'(r_t5_den) << QW;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dvx[0] <= '{rem: r_t5_num_x, q: '0, sat: (r_t5_num_x >= w_dlim), neg: r_t5_neg_x};
            r_dvy[0] <= '{rem: r_t5_num_y, q: '0, sat: (r_t5_num_y >= w_dlim), neg: r_t5_neg_y};
            r_den[0] <= r_t5_den;
        end
    end

    // Restoring division, one quotient bit per stage from the top.
    for (genvar j = 1; j <= QW; j++) begin : g_div
        logic [NUMW-1:0] n_dsh;
        logic            n_tx, n_ty;
        assign n_dsh = NUMW'(r_den[j-1]) << (QW - j);
        assign n_tx  = (r_dvx[j-1].rem >= n_dsh);
        assign n_ty  = (r_dvy[j-1].rem >= n_dsh);
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dvx[j].rem <= n_tx ? r_dvx[j-1].rem - n_dsh : r_dvx[j-1].rem;
                r_dvx[j].q   <= r_dvx[j-1].q | (n_tx ? QW'(1) << (QW - j) : QW'(0));
                r_dvx[j].sat <= r_dvx[j-1].sat;
                r_dvx[j].neg <= r_dvx[j-1].neg;
                r_dvy[j].rem <= n_ty ? r_dvy[j-1].rem - n_dsh : r_dvy[j-1].rem;
                r_dvy[j].q   <= r_dvy[j-1].q | (n_ty ? QW'(1) << (QW - j) : QW'(0));
                r_dvy[j].sat <= r_dvy[j-1].sat;
                r_dvy[j].neg <= r_dvy[j-1].neg;
            end
        end
        if (j < QW) begin : g_den
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_den[j] <= r_den[j-1];
                end
            end
        end
    end

    // Translate back to field coordinates.
    logic [VW-1:0]        w_vx, w_vy;
    logic signed [SW-1:0] r_sum_x, r_sum_y;
    assign w_vx = r_dvx[QW].sat ? (VW'(1) << QW) : VW'(r_dvx[QW].q);
    assign w_vy = r_dvy[QW].sat ? (VW'(1) << QW) : VW'(r_dvy[QW].q);
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sum_x <= r_dvx[QW].neg ? SW'(r_car[PL-1].rx) - $signed(SW'(w_vx))
                                     : SW'(r_car[PL-1].rx) + $signed(SW'(w_vx));
            r_sum_y <= r_dvy[QW].neg ? SW'(r_car[PL-1].ry) - $signed(SW'(w_vy))
                                     : SW'(r_car[PL-1].ry) + $signed(SW'(w_vy));
        end
    end

    // Output register: saturate, or pass the endpoint for a degenerate segment.
    logic signed [SW-1:0] n_sat_x, n_sat_y;
    logic                 n_clip_x, n_clip_y;
    always_comb begin
        n_clip_x = (r_sum_x > pplp_pkg::LIM_HI) || (r_sum_x < pplp_pkg::LIM_LO);
        n_clip_y = (r_sum_y > pplp_pkg::LIM_HI) || (r_sum_y < pplp_pkg::LIM_LO);
        n_sat_x  = (r_sum_x > pplp_pkg::LIM_HI) ? pplp_pkg::LIM_HI :
                   (r_sum_x < pplp_pkg::LIM_LO) ? pplp_pkg::LIM_LO : r_sum_x;
        n_sat_y  = (r_sum_y > pplp_pkg::LIM_HI) ? pplp_pkg::LIM_HI :
                   (r_sum_y < pplp_pkg::LIM_LO) ? pplp_pkg::LIM_LO : r_sum_y;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_car[PL].degen) begin
                o_m_axis_tdata <= {r_car[PL].ey, r_car[PL].ex};
                o_m_axis_tuser[pplp_pkg::U_DEGEN] <= 1'b1;
                o_m_axis_tuser[pplp_pkg::U_CLIP]  <= 1'b0;
            end else begin
                o_m_axis_tdata <= {n_sat_y[CW-1:0], n_sat_x[CW-1:0]};
                o_m_axis_tuser[pplp_pkg::U_DEGEN] <= 1'b0;
                o_m_axis_tuser[pplp_pkg::U_CLIP]  <= n_clip_x || n_clip_y;
            end
        end
    end

endmodule

[hw/rtl/pplp_checker.sv]
// Port level checks for pure_pursuit_lookahead_point, and the bind that attaches them.
// Depends on pplp_pkg.
module pplp_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    input  logic                           o_s_axis_tready,
    input  logic [pplp_pkg::IN_W-1:0]      i_s_axis_tdata,
    input  logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    input  logic [pplp_pkg::OUT_W-1:0]     o_m_axis_tdata,
    input  logic [pplp_pkg::USER_W-1:0]    o_m_axis_tuser
);

    // A stalled result holds its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled result changed");

    // The input side stalls exactly when a result waits at the output.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready == !(o_m_axis_tvalid && !i_m_axis_tready))
        else $error("input ready does not follow the output stall");

    // A degenerate segment never reports a clipped point.
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(o_m_axis_tuser[pplp_pkg::U_DEGEN] &&
                              o_m_axis_tuser[pplp_pkg::U_CLIP]))
        else $error("degenerate and clipped both set");

    // Reset empties the pipeline.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind pure_pursuit_lookahead_point pplp_checker u_pplp_checker (.*);

[tb/testbench.sv]
// Self-checking testbench for pure_pursuit_lookahead_point: directed and random
// queries through the stream ports, checked against a wide-integer geometry predictor.
// Depends on pplp_pkg and the block's RTL.
module testbench;

    localparam int CW      = pplp_pkg::CW;
    localparam int LAW     = pplp_pkg::LAW;
    localparam int IN_W    = pplp_pkg::IN_W;
    localparam int OUT_W   = pplp_pkg::OUT_W;
    localparam int USER_W  = pplp_pkg::USER_W;
    localparam int DEPTH   = pplp_pkg::DEPTH;
    localparam int U_DEGEN = pplp_pkg::U_DEGEN;
    localparam int U_CLIP  = pplp_pkg::U_CLIP;

    typedef logic signed [255:0] t_wide;

    typedef struct {
        logic signed [CW-1:0] aim_x;
        logic signed [CW-1:0] aim_y;
        logic                 degenerate;
        logic                 clipped;
    } t_aim;

    typedef struct {
        logic signed [CW-1:0] rx, ry, sx, sy, ex, ey;
        logic [LAW-1:0]       la;
        bit                   typed;
        t_aim                 aim;
    } t_query;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_s_axis_tvalid = 1'b0;
    logic               o_s_axis_tready;
    logic [IN_W-1:0]    i_s_axis_tdata = '0;
    logic               o_m_axis_tvalid;
    logic               i_m_axis_tready = 1'b0;
    logic [OUT_W-1:0]   o_m_axis_tdata;
    logic [USER_W-1:0]  o_m_axis_tuser;

    t_aim   aim_queue[$];
    int     error_count = 0;
    int     accepted = 0;
    bit     long_hold_done = 0;

    pure_pursuit_lookahead_point u_top (.*);

    // Clock with period 20.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Exact integer square root, floor.
    function automatic t_wide isqrt(t_wide a);
        t_wide root, cand;
        root = '0;
        for (int i = 79; i >= 0; i--) begin
            cand = root | (t_wide'(1) <<< i);
            if (cand * cand <= a) root = cand;
        end
        return root;
    endfunction

    // Quotient rounded to nearest, ties away from zero, magnitude limited.
    function automatic t_wide round_quot(t_wide n, t_wide dr);
        t_wide mag, q, lim;
        mag = (n < 0) ? -n : n;
        q = (2 * mag + dr) / (2 * dr);
        lim = t_wide'(1) <<< (CW + 1);
        if (q >= lim) q = lim;
        return (n < 0) ? -q : q;
    endfunction

    // Translate back to field coordinates and saturate.
    function automatic logic signed [CW-1:0] place_coord(t_wide rel, t_wide base,
                                                          inout logic clip);
        t_wide v, hi, lo;
        v = rel + base;
        hi = (t_wide'(1) <<< (CW - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) begin
            v = hi;
            clip = 1'b1;
        end
        if (v < lo) begin
            v = lo;
            clip = 1'b1;
        end
        return v[CW-1:0];
    endfunction

    // Lookahead point for one query.
    function automatic t_aim lookahead_point(t_query c);
        t_wide rx, ry, x1, y1, x2, y2, dx, dy, dr, d, la, disc, root, w, ux, uy, nx, ny;
        t_aim r;
        logic clip;
        rx = t_wide'(c.rx);
        ry = t_wide'(c.ry);
        x1 = t_wide'(c.sx) - rx;
        y1 = t_wide'(c.sy) - ry;
        x2 = t_wide'(c.ex) - rx;
        y2 = t_wide'(c.ey) - ry;
        dx = x2 - x1;
        dy = y2 - y1;
        clip = 1'b0;
        if (dx == 0 && dy == 0) begin
            r.aim_x = c.ex;
            r.aim_y = c.ey;
            r.degenerate = 1'b1;
            r.clipped = 1'b0;
            return r;
        end
        la = t_wide'({1'b0, c.la});
        dr = dx * dx + dy * dy;
        d = x1 * y2 - x2 * y1;
        disc = la * la * dr - d * d;
        if (disc < 0) disc = -disc;
        root = isqrt(disc);
        // Take the candidate nearer the endpoint; ties go to the plus candidate.
        w = dx * x2 + dy * y2;
        if (!(root == 0 || w == 0 || ((w < 0) == (dy < 0)))) root = -root;
        ux = (dy < 0) ? -dx : dx;
        uy = (dy < 0) ? -dy : dy;
        nx = d * dy + ux * root;
        ny = -(d * dx) + uy * root;
        r.aim_x = place_coord(round_quot(nx, dr), rx, clip);
        r.aim_y = place_coord(round_quot(ny, dr), ry, clip);
        r.degenerate = 1'b0;
        r.clipped = clip;
        return r;
    endfunction

    // Send one query, holding tvalid high across back-to-back transfers.
    task automatic send_query(t_query c);
        int gap;
        t_aim want;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
        if (accepted % 200 > 150) gap = 0;
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {1'b0, c.la, c.ey, c.ex, c.sy, c.sx, c.ry, c.rx};
        do @(posedge i_clk); while (!o_s_axis_tready);
        if (c.typed) want = c.aim;
        else want = lookahead_point(c);
        aim_queue.push_back(want);
        accepted++;
    endtask

    function automatic logic signed [CW-1:0] rand_coord(int mode);
        case (mode)
            0: return $urandom;
            1: return $signed($urandom_range(0, 4000)) - 2000;
            2: return $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
            default: return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
        endcase
    endfunction

    function automatic t_query random_query();
        t_query c;
        int mode;
        mode = $urandom_range(0, 9);
        mode = (mode < 2) ? 0 : (mode < 5) ? 1 : (mode < 9) ? 2 : 3;
        c.typed = 0;
        c.rx = rand_coord(mode);
        c.ry = rand_coord(mode);
        c.sx = rand_coord(mode);
        c.sy = rand_coord(mode);
        c.ex = rand_coord(mode);
        c.ey = rand_coord(mode);
        // Mostly a radius in scale with the coordinates, sometimes any value.
        if (mode == 0 || $urandom_range(0, 4) == 0) c.la = LAW'($urandom);
        else if (mode == 1) c.la = LAW'($urandom_range(0, 3000));
        else c.la = LAW'($urandom_range(0, 32'h00ff_ffff));
        // Now and then the endpoints coincide.
        if ($urandom_range(0, 19) == 0) begin
            c.ex = c.sx;
            c.ey = c.sy;
        end
        return c;
    endfunction

    function automatic t_query row(int rx, int ry, int sx, int sy, int ex, int ey,
                                   int la);
        t_query c;
        c.rx = rx; c.ry = ry; c.sx = sx; c.sy = sy; c.ex = ex; c.ey = ey;
        c.la = la[LAW-1:0];
        c.typed = 0;
        return c;
    endfunction

    function automatic t_query typed_row(t_query c, int ax, int ay, bit dg, bit cl);
        c.typed = 1;
        c.aim.aim_x = ax;
        c.aim.aim_y = ay;
        c.aim.degenerate = dg;
        c.aim.clipped = cl;
        return c;
    endfunction

    // Sender: reset, directed table, then random queries.
    initial begin
        localparam int MX = 32'sh7fff_ffff;
        localparam int MN = 32'sh8000_0000;
        t_query table_rows[$];
        table_rows.push_back(typed_row(row(0, 0, 5, 7, 5, 7, 100), 5, 7, 1, 0));
        table_rows.push_back(typed_row(row(MX, MN, MN, MX, MN, MX, MX), MN, MX, 1, 0));
        table_rows.push_back(typed_row(row(MN, MN, 0, 0, 0, 0, 0), 0, 0, 1, 0));
        // Lines through the robot: the point at the radius on the endpoint side.
        table_rows.push_back(typed_row(row(0, 0, -100, 0, 100, 0, 50), 50, 0, 0, 0));
        table_rows.push_back(typed_row(row(0, 0, 100, 0, -100, 0, 50), -50, 0, 0, 0));
        table_rows.push_back(typed_row(row(0, 0, 0, -100, 0, 100, 30), 0, 30, 0, 0));
        table_rows.push_back(typed_row(row(0, 0, 0, 100, 0, -100, 30), 0, -30, 0, 0));
        table_rows.push_back(row(0, 0, -100, 10, 100, 10, 0));
        table_rows.push_back(row(0, 0, -100, 500, 100, 500, 20));
        table_rows.push_back(row(3, -4, 1, 1, 9, 5, 10));
        table_rows.push_back(row(0, 0, MN, MN, MX, MX, MX));
        table_rows.push_back(row(MX, MX, MN, MN, MX, MN, MX));
        table_rows.push_back(row(MN, MN, MX, MX, MX, MN, 1));
        table_rows.push_back(row(MN, MX, MX, MN, MN + 1, MX - 1, MX));
        table_rows.push_back(row(MX, 0, MN, 1, MN, 0, 0));
        table_rows.push_back(row(-1, -1, 0, 0, 1, 0, 1));
        table_rows.push_back(row(0, 0, 0, 0, 1, 1, MX));
        table_rows.push_back(row(12345, -999, 0, 65536, 65536, 0, 65536));
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (table_rows[k]) send_query(table_rows[k]);
        repeat (900) send_query(random_query());
        i_s_axis_tvalid <= 1'b0;
        while (aim_queue.size() != 0) @(posedge i_clk);
        repeat (DEPTH + 20) @(posedge i_clk);
        if (error_count == 0) $display("testbench: clean");
        else $display("testbench: errors");
        $finish;
    end

    // Receiver: random stalls, runs without stalls, and one long hold-off.
    initial begin
        int stall;
        @(posedge i_clk iff i_rst_n);
        forever begin
            stall = $urandom_range(0, 3);
            if (accepted % 300 < 60) stall = 0;
            if (!long_hold_done && accepted >= 300) begin
                stall = 3 * DEPTH;
                long_hold_done = 1;
            end
            if (stall > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
        end
    end

    // Compare each result transfer with the oldest expectation.
    always @(posedge i_clk) begin
        t_aim want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (aim_queue.size() == 0) begin
                $error("result transfer with no expectation waiting");
                error_count++;
            end else begin
                want = aim_queue.pop_front();
                if (o_m_axis_tdata[CW-1:0] !== want.aim_x) begin
                    $error("aim_x: expected %0d, got %0d", want.aim_x,
                           $signed(o_m_axis_tdata[CW-1:0]));
                    error_count++;
                end
                if (o_m_axis_tdata[2*CW-1:CW] !== want.aim_y) begin
                    $error("aim_y: expected %0d, got %0d", want.aim_y,
                           $signed(o_m_axis_tdata[2*CW-1:CW]));
                    error_count++;
                end
                if (o_m_axis_tuser[U_DEGEN] !== want.degenerate) begin
                    $error("degenerate: expected %0b, got %0b", want.degenerate,
                           o_m_axis_tuser[U_DEGEN]);
                    error_count++;
                end
                if (o_m_axis_tuser[U_CLIP] !== want.clipped) begin
                    $error("clipped: expected %0b, got %0b", want.clipped,
                           o_m_axis_tuser[U_CLIP]);
                    error_count++;
                end
            end
        end
    end

    // Watchdog.
    initial begin
        #8000000;
        $display("testbench: errors");
        $finish;
    end

endmodule
